/* src/gexp_pkg.sv */
// Shared types, constants and CRC helper for the GPIO expander readback block.
package gexp_pkg;

  localparam int PIN_COUNT   = 16;
  localparam int REPLY_BYTES = 9;
  localparam int SNAP_BYTES  = 7;
  localparam int BW_W        = 3;
  localparam int RIDX_W      = 4;
  localparam int CNT_W       = 3;

  localparam logic [7:0]  CMD_WRITE_ALL = 8'h30;
  localparam logic [7:0]  CMD_SNAPSHOT  = 8'h60;
  localparam logic [7:0]  BUS_IDLE_BYTE = 8'hFF;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_TOP       = 16'h8000;
  localparam logic [BW_W-1:0]   BW_MAX    = 3'd7;
  localparam logic [RIDX_W-1:0] RIDX_NONE = 4'(REPLY_BYTES);
  localparam logic [RIDX_W-1:0] RIDX_CRC_HI = 4'(SNAP_BYTES);
  localparam logic [CNT_W-1:0]  CNT_DONE  = 3'(SNAP_BYTES);

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           byte_in;
    logic [PIN_COUNT-1:0] pin_levels;
  } item_t;

  typedef struct packed {
    logic [7:0]           read_byte;
    logic [PIN_COUNT-1:0] direction;
    logic [PIN_COUNT-1:0] port_latch;
    logic                 bad_command;
  } result_t;

  typedef struct packed {
    logic                        start;
    logic [SNAP_BYTES-1:0][7:0]  bytes;
  } crc_req_t;

  typedef struct packed {
    logic        busy;
    logic [15:0] value;
  } crc_stat_t;

  // One byte of CRC-16/CCITT, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] v;
    v = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((v & CRC_TOP) != 16'h0000) begin
        v = {v[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[14:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

/* src/gexp_if.sv */
// Valid/ready channel interfaces for bus events and result words.
interface gexp_in_if;
  import gexp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [7:0]           byte_in;
  logic [PIN_COUNT-1:0] pin_levels;
  modport source (output valid, kind, byte_in, pin_levels, input ready);
  modport sink   (input valid, kind, byte_in, pin_levels, output ready);
endinterface

interface gexp_out_if;
  import gexp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [7:0]           read_byte;
  logic [PIN_COUNT-1:0] direction;
  logic [PIN_COUNT-1:0] port_latch;
  logic                 bad_command;
  modport source (output valid, read_byte, direction, port_latch, bad_command, input ready);
  modport sink   (input valid, read_byte, direction, port_latch, bad_command, output ready);
endinterface

/* src/gexp_crc.sv */
// Background CRC-16/CCITT engine: one snapshot byte per cycle after a start.
module gexp_crc (
  input  logic                clk,
  input  logic                rst_n,
  input  gexp_pkg::crc_req_t  req,
  output gexp_pkg::crc_stat_t stat
);
  import gexp_pkg::*;

  logic [15:0]                crc_r, crc_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [SNAP_BYTES-1:0][7:0] shift_r, shift_nxt;

  always_comb begin
    crc_nxt   = crc_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    if (req.start) begin
      crc_nxt   = CRC_INIT;
      cnt_nxt   = '0;
      shift_nxt = req.bytes;
    end else if (cnt_r != CNT_DONE) begin
      // fold in the lowest byte, then advance the line
      crc_nxt   = crc_byte(crc_r, shift_r[0]);
      cnt_nxt   = cnt_r + 3'd1;
      shift_nxt = shift_r >> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      cnt_r <= CNT_DONE;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
    end
    shift_r <= shift_nxt;
  end

  assign stat.busy  = (cnt_r != CNT_DONE);
  assign stat.value = crc_r;

  a_start_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> cnt_r == '0)
    else $error("crc count not cleared by start");

  a_idle_holds_crc: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CNT_DONE && !req.start) |=> $stable(crc_r))
    else $error("crc changed while idle");

endmodule

/* src/gexp_ctrl.sv */
// Command decode, port registers and reply store; one event per proc cycle.
module gexp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                proc,
  input  gexp_pkg::item_t     item,
  input  gexp_pkg::crc_stat_t crc,
  output gexp_pkg::crc_req_t  crc_req,
  output gexp_pkg::result_t   res
);
  import gexp_pkg::*;

  logic [PIN_COUNT-1:0]       dir_r, dir_nxt;
  logic [PIN_COUNT-1:0]       latch_r, latch_nxt;
  logic [7:0]                 cmd_r, cmd_nxt;
  logic [BW_W-1:0]            bw_r, bw_nxt;
  logic [RIDX_W-1:0]          ridx_r, ridx_nxt;
  logic [7:0]                 staged_r [3];
  logic [7:0]                 staged_nxt [3];
  logic [SNAP_BYTES-1:0][7:0] reply_r;
  logic [SNAP_BYTES-1:0][7:0] snap_bytes;
  logic                       snap_take;
  logic [7:0]                 rd;

  always_comb begin
    snap_bytes[0] = dir_r[7:0];
    snap_bytes[1] = dir_r[15:8];
    snap_bytes[2] = latch_r[7:0];
    snap_bytes[3] = latch_r[15:8];
    snap_bytes[4] = item.pin_levels[7:0];
    snap_bytes[5] = item.pin_levels[15:8];
    snap_bytes[6] = 8'h00;
  end

  always_comb begin
    dir_nxt    = dir_r;
    latch_nxt  = latch_r;
    cmd_nxt    = cmd_r;
    bw_nxt     = bw_r;
    ridx_nxt   = ridx_r;
    staged_nxt = staged_r;
    snap_take  = 1'b0;
    rd         = BUS_IDLE_BYTE;
    unique case (item.kind)
      KIND_START: begin
        bw_nxt  = '0;
        cmd_nxt = 8'h00;
      end
      KIND_WRITE: begin
        if (bw_r == '0) begin
          cmd_nxt = item.byte_in;
          bw_nxt  = 3'd1;
          if (item.byte_in == CMD_SNAPSHOT) begin
            snap_take = 1'b1;
            ridx_nxt  = '0;
          end
        end else begin
          if (cmd_r == CMD_WRITE_ALL && bw_r <= 3'd4) begin
            if (bw_r < 3'd4) begin
              staged_nxt[bw_r[1:0] - 2'd1] = item.byte_in;
            end else begin
              dir_nxt   = {staged_r[1], staged_r[0]};
              latch_nxt = {item.byte_in, staged_r[2]};
            end
          end
          if (bw_r < BW_MAX) begin
            bw_nxt = bw_r + 3'd1;
          end
        end
      end
      KIND_READ: begin
        if (ridx_r < RIDX_NONE) begin
          priority if (ridx_r < RIDX_CRC_HI) begin
            rd = reply_r[ridx_r[2:0]];
          end else if (ridx_r == RIDX_CRC_HI) begin
            rd = crc.value[15:8];
          end else begin
            rd = crc.value[7:0];
          end
          ridx_nxt = ridx_r + 4'd1;
        end
      end
      default: begin
        // bus idle: nothing changes
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= '0;
      latch_r  <= '0;
      cmd_r    <= '0;
      bw_r     <= '0;
      ridx_r   <= RIDX_NONE;
      staged_r <= '{default: '0};
    end else if (proc) begin
      dir_r    <= dir_nxt;
      latch_r  <= latch_nxt;
      cmd_r    <= cmd_nxt;
      bw_r     <= bw_nxt;
      ridx_r   <= ridx_nxt;
      staged_r <= staged_nxt;
    end
    if (proc && snap_take) begin
      reply_r <= snap_bytes;
    end
  end

  assign crc_req.start = proc && snap_take;
  assign crc_req.bytes = snap_bytes;

  assign res.read_byte   = rd;
  assign res.direction   = dir_nxt;
  assign res.port_latch  = latch_nxt;
  assign res.bad_command = (bw_nxt != '0) && (cmd_nxt != CMD_WRITE_ALL) &&
                           (cmd_nxt != CMD_SNAPSHOT);

  a_ridx_range: assert property (@(posedge clk) disable iff (!rst_n)
    ridx_r <= RIDX_NONE)
    else $error("reply index out of range");

  a_crc_ready_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && item.kind == KIND_READ && ridx_r >= RIDX_CRC_HI && ridx_r < RIDX_NONE)
      |-> !crc.busy)
    else $error("crc byte read before crc finished");

endmodule

/* src/gpio_expander_crc_readback.sv */
// Top level of the GPIO expander bus side with CRC-checked status readback.
//
// in_ch carries one bus event per word: kind (start, host write, host read),
// the written byte and the sampled pin levels. out_ch returns exactly one
// word per event: the reply byte for a read (0xFF when no reply is pending
// or for non-read events), the direction and latch registers after the
// event, and the unknown-command flag.
// Each event is captured in an input register and resolved by one stage of
// logic into the output register, so its word passes both registers in turn;
// one event is taken every cycle while out_ch does not stall. The CRC over
// the seven snapshot bytes is folded one byte per cycle by a background
// engine that finishes before the first CRC byte can be read.
// Reset (synchronous, rst_n low) clears the port registers to zero (all
// pins input), drops any pending reply and empties both registers.
// When out_ch stalls, the output word holds; one more event waits in the
// input register and in_ch.ready then drops until the output drains.
module gpio_expander_crc_readback (
  input logic       clk,
  input logic       rst_n,
  gexp_in_if.sink   in_ch,
  gexp_out_if.source out_ch
);
  import gexp_pkg::*;

  item_t     item_r;
  logic      in_vld_r;
  result_t   res, res_r;
  logic      out_vld_r;
  logic      fire;
  crc_req_t  crc_req;
  crc_stat_t crc_stat;

  assign fire        = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
    if (in_ch.valid && in_ch.ready) begin
      item_r.kind       <= in_ch.kind;
      item_r.byte_in    <= in_ch.byte_in;
      item_r.pin_levels <= in_ch.pin_levels;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  gexp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .proc    (fire),
    .item    (item_r),
    .crc     (crc_stat),
    .crc_req (crc_req),
    .res     (res)
  );

  gexp_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (crc_req),
    .stat  (crc_stat)
  );

  assign out_ch.valid       = out_vld_r;
  assign out_ch.read_byte   = res_r.read_byte;
  assign out_ch.direction   = res_r.direction;
  assign out_ch.port_latch  = res_r.port_latch;
  assign out_ch.bad_command = res_r.bad_command;

  a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("processed word did not reach output register");

endmodule
